[design/mipmap_trilinear_sampler_defines.svh]
// ---------------------------------------------------------------------------
// Mipmap trilinear sampler assertion macros
// Concurrent check helpers, empty when synthesised.
// ---------------------------------------------------------------------------
`ifndef MIPMAP_TRILINEAR_SAMPLER_DEFINES_SVH
`define MIPMAP_TRILINEAR_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define MTS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mts: check failed");
`define MTS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mts: check failed");
`else
`define MTS_ASSERT_IMP(name, clk, rst, ante, cons)
`define MTS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

[design/mts_pkg.sv]
// ---------------------------------------------------------------------------
// mts_pkg
// Shared types, codes and defaults of the mipmap trilinear sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

   localparam int MAX_LOG_SIZE_DEF = 8;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [1:0] WRAP_REPEAT = 2'd0;
   localparam logic [1:0] WRAP_CLAMP  = 2'd1;

   localparam logic [1:0] REG_WRAP  = 2'd0;
   localparam logic [1:0] REG_LOG_W = 2'd1;
   localparam logic [1:0] REG_LOG_H = 2'd2;

   localparam logic [1:0] WRAP_RESET  = 2'd0;
   localparam logic [3:0] LOG_W_RESET = 4'd8;
   localparam logic [3:0] LOG_H_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         texel_col;
      logic [7:0]         texel_row;
      logic [15:0]        texel_value;
      logic signed [31:0] coord_s;
      logic signed [31:0] coord_t;
      logic signed [31:0] deriv0_s;
      logic signed [31:0] deriv0_t;
      logic signed [31:0] deriv1_s;
      logic signed [31:0] deriv1_t;
   } req_type;

   typedef struct packed {
      logic [15:0] sample_value;
      logic        is_sample;
   } rsp_type;

   typedef struct packed {
      logic [1:0] wrap_mode;
      logic [3:0] log_width;
      logic [3:0] log_height;
   } cfg_type;

   typedef enum logic [14:0] {
      S_IDLE    = 15'h0001,
      S_NORM    = 15'h0002,
      S_BASE    = 15'h0004,
      S_SETUP   = 15'h0008,
      S_TAP_RD  = 15'h0010,
      S_TAP_MUL = 15'h0020,
      S_TAP_ACC = 15'h0040,
      S_BIL_END = 15'h0080,
      S_BLEND1  = 15'h0100,
      S_BLEND2  = 15'h0200,
      S_BLEND3  = 15'h0400,
      S_BLD_RD  = 15'h0800,
      S_BLD_ACC = 15'h1000,
      S_BLD_WR  = 15'h2000,
      S_OUT     = 15'h4000
   } state_type;

endpackage

[design/mts_mul.sv]
// ---------------------------------------------------------------------------
// mts_mul
// Shared 33x17 multiplier with registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_mul (
   input  logic        clock,
   input  logic [32:0] op_a,
   input  logic [16:0] op_b,
   output logic [49:0] prod
);

   logic [49:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 50'(op_a) * 50'(op_b);
   end

   assign prod = prod_ff;

endmodule

[design/mts_store.sv]
// ---------------------------------------------------------------------------
// mts_store
// Texel memory holding all pyramid levels, one write and one read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_store #(
   parameter int DEPTH  = 87381,
   parameter int ADDR_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

[design/mts_seq.sv]
// ---------------------------------------------------------------------------
// mts_seq
// Sequencer: write, pyramid build and trilinear lookup over one texel
// memory and one shared multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_seq
   import mts_pkg::*;
#(
   parameter int MAX_LOG_SIZE = MAX_LOG_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int M      = MAX_LOG_SIZE;
   localparam int DEPTH  = ((1 << (2 * M + 2)) - 1) / 3;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LOG_W  = $clog2(M + 1);
   localparam int LVL_W  = $clog2(M + 2);
   localparam int CW     = M + 18;
   localparam int XW     = M + 34;
   localparam int HI_W   = $clog2(M + 17) + 1;

   function automatic logic [LOG_W-1:0] lvl_log(input logic [LOG_W-1:0] eff,
                                                 input logic [LVL_W-1:0] k);
      if (int'(k) >= int'(eff)) begin
         return '0;
      end
      return LOG_W'(int'(eff) - int'(k));
   endfunction

   function automatic logic [ADDR_W-1:0] lvl_size(input logic [LOG_W-1:0] a,
                                                   input logic [LOG_W-1:0] b);
      logic [ADDR_W-1:0] one;
      one = ADDR_W'(1);
      return one << (int'(a) + int'(b));
   endfunction

   state_type state_ff, state_in;
   logic signed [31:0] cs_ff, cs_in, ct_ff, ct_in;
   logic [32:0]        norm_ff, norm_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in, walk_ff, walk_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [7:0]         d_ff, d_in;
   logic               point_ff, point_in, phase_ff, phase_in;
   logic signed [CW-1:0] s0_ff, s0_in, t0_ff, t0_in;
   logic [15:0]        fs_ff, fs_in, ft_ff, ft_in;
   logic [1:0]         tap_ff, tap_in;
   logic [49:0]        acc_ff, acc_in;
   logic [15:0]        bila_ff, bila_in, bilb_ff, bilb_in, res_ff, res_in;
   logic               smp_ff, smp_in, black_ff, black_in;
   logic [M-1:0]       bs_ff, bs_in, bt_ff, bt_in;
   logic [17:0]        sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [LOG_W-1:0]   eff_lw, eff_lh, top_lvl;
   logic [LOG_W-1:0]   f_lw, f_lh, nx_lw, nx_lh;
   logic signed [CW-1:0] f_s, f_t, f_w, f_h, s_e, t_e;
   logic               f_black;
   logic [ADDR_W-1:0]  f_addr;
   logic               accept;
   logic signed [31:0] m01, m23, mx;
   logic               wr_in_range;
   logic [ADDR_W-1:0]  w_addr, b_addr;
   logic signed [HI_W-1:0] lev_hi, top_hi;
   logic signed [XW-1:0] xs, xt;
   logic [16:0]        ws, wt;
   logic [49:0]        rnd;
   logic [24:0]        blend;
   logic [M-1:0]       bw_mask, bh_mask;
   logic               st_wr_en;
   logic [ADDR_W-1:0]  st_wr_addr;
   logic [15:0]        st_wr_data, rd_data, texel;
   logic [32:0]        mul_a;
   logic [16:0]        mul_b;
   logic [49:0]        mul_p;

   mts_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (f_addr),
      .rd_data (rd_data)
   );

   mts_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   assign eff_lw  = LOG_W'((cfg.log_width > 4'(M)) ? 4'(M) : cfg.log_width);
   assign eff_lh  = LOG_W'((cfg.log_height > 4'(M)) ? 4'(M) : cfg.log_height);
   assign top_lvl = (eff_lw > eff_lh) ? eff_lw : eff_lh;
   assign accept  = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign texel = black_ff ? 16'd0 : rd_data;

   // texel address unit with wrap handling
   assign f_lw  = lvl_log(eff_lw, lvl_ff);
   assign f_lh  = lvl_log(eff_lh, lvl_ff);
   assign nx_lw = lvl_log(eff_lw, lvl_ff + LVL_W'(1));
   assign nx_lh = lvl_log(eff_lh, lvl_ff + LVL_W'(1));
   assign f_w   = CW'(1) << f_lw;
   assign f_h   = CW'(1) << f_lh;

   always_comb begin
      if (state_ff == S_BLD_RD) begin
         f_s = CW'({bs_ff, tap_ff[1]});
         f_t = CW'({bt_ff, tap_ff[0]});
      end else begin
         f_s = s0_ff + CW'(tap_ff[1]);
         f_t = t0_ff + CW'(tap_ff[0]);
      end
      f_black = 1'b0;
      case (cfg.wrap_mode)
         WRAP_REPEAT: begin
            s_e = f_s & (f_w - CW'(1));
            t_e = f_t & (f_h - CW'(1));
         end
         WRAP_CLAMP: begin
            s_e = (f_s < 0) ? '0 : ((f_s >= f_w) ? f_w - CW'(1) : f_s);
            t_e = (f_t < 0) ? '0 : ((f_t >= f_h) ? f_h - CW'(1) : f_t);
         end
         default: begin
            s_e = f_s;
            t_e = f_t;
            f_black = (f_s < 0) || (f_s >= f_w) || (f_t < 0) || (f_t >= f_h);
         end
      endcase
      f_addr = base_ff + (ADDR_W'(t_e) << f_lw) + ADDR_W'(s_e);
   end

   assign m01 = (req_payload.deriv0_t > req_payload.deriv0_s) ?
                req_payload.deriv0_t : req_payload.deriv0_s;
   assign m23 = (req_payload.deriv1_t > req_payload.deriv1_s) ?
                req_payload.deriv1_t : req_payload.deriv1_s;
   assign mx  = (m23 > m01) ? m23 : m01;

   assign wr_in_range = ((req_payload.texel_col >> eff_lw) == 8'd0) &&
                        ((req_payload.texel_row >> eff_lh) == 8'd0);
   assign w_addr = (ADDR_W'(req_payload.texel_row) << eff_lw) +
                   ADDR_W'(req_payload.texel_col);
   assign b_addr = base_ff + lvl_size(f_lw, f_lh) + (ADDR_W'(bt_ff) << nx_lw) +
                   ADDR_W'(bs_ff);
   assign bw_mask = M'((1 << int'(nx_lw)) - 1);
   assign bh_mask = M'((1 << int'(nx_lh)) - 1);

   assign top_hi = $signed(HI_W'(top_lvl));
   assign lev_hi = top_hi + $signed(HI_W'(16)) - $signed(HI_W'(cnt_ff));

   assign xs = (XW'(cs_ff) <<< f_lw) - XW'(32768);
   assign xt = (XW'(ct_ff) <<< f_lh) - XW'(32768);
   assign ws = tap_ff[1] ? 17'(fs_ff) : 17'h10000 - 17'(fs_ff);
   assign wt = tap_ff[0] ? 17'(ft_ff) : 17'h10000 - 17'(ft_ff);
   assign rnd   = acc_ff + 50'h0_8000_0000;
   assign blend = acc_ff[24:0] + mul_p[24:0] + 25'd128;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_TAP_RD: begin
            mul_a = 33'(ws);
            mul_b = wt;
         end
         S_TAP_MUL: begin
            mul_a = mul_p[32:0];
            mul_b = 17'(texel);
         end
         S_BLEND1: begin
            mul_a = 33'(bila_ff);
            mul_b = 17'(9'd256 - 9'(d_ff));
         end
         S_BLEND2: begin
            mul_a = 33'(bilb_ff);
            mul_b = 17'(d_ff);
         end
         default: begin
         end
      endcase
   end

   assign st_wr_en   = (accept && (req_payload.command == CMD_WRITE) && wr_in_range) ||
                       (state_ff == S_BLD_WR);
   assign st_wr_addr = (state_ff == S_BLD_WR) ? b_addr : w_addr;
   assign st_wr_data = (state_ff == S_BLD_WR) ? 16'((sum_ff + 18'd2) >> 2) :
                       req_payload.texel_value;

   always_comb begin
      state_in = state_ff;
      cs_in = cs_ff;       ct_in = ct_ff;
      norm_in = norm_ff;   cnt_in = cnt_ff;
      lvl_in = lvl_ff;     walk_in = walk_ff;   base_in = base_ff;
      d_in = d_ff;         point_in = point_ff; phase_in = phase_ff;
      s0_in = s0_ff;       t0_in = t0_ff;       fs_in = fs_ff;   ft_in = ft_ff;
      tap_in = tap_ff;     acc_in = acc_ff;
      bila_in = bila_ff;   bilb_in = bilb_ff;   res_in = res_ff; smp_in = smp_ff;
      black_in = black_ff; bs_in = bs_ff;       bt_in = bt_ff;   sum_in = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               smp_in = 1'b0;
               cs_in = req_payload.coord_s;
               ct_in = req_payload.coord_t;
               lvl_in = '0;
               walk_in = '0;
               base_in = '0;
               bs_in = '0;
               bt_in = '0;
               tap_in = '0;
               sum_in = '0;
               d_in = '0;
               point_in = 1'b0;
               phase_in = 1'b0;
               norm_in = {mx, 1'b0};
               cnt_in = '0;
               unique case (req_payload.command)
                  CMD_BUILD: begin
                     state_in = (top_lvl == '0) ? S_OUT : S_BLD_RD;
                  end
                  CMD_LOOKUP: begin
                     smp_in = 1'b1;
                     state_in = (!mx[31] && (mx != 32'sd0)) ? S_NORM : S_BASE;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_NORM: begin
            if (norm_ff[32]) begin
               state_in = S_BASE;
               if (lev_hi < 0) begin
                  lvl_in = '0;
                  d_in = '0;
               end else if ((lev_hi > top_hi) ||
                            ((lev_hi == top_hi) && (norm_ff[31:24] != 8'd0))) begin
                  lvl_in = LVL_W'(top_lvl);
                  d_in = '0;
                  point_in = 1'b1;
               end else begin
                  lvl_in = LVL_W'(lev_hi);
                  d_in = norm_ff[31:24];
               end
            end else begin
               norm_in = {norm_ff[31:0], 1'b0};
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_BASE: begin
            if (walk_ff == lvl_ff) begin
               state_in = S_SETUP;
            end else begin
               base_in = base_ff + lvl_size(lvl_log(eff_lw, walk_ff),
                                            lvl_log(eff_lh, walk_ff));
               walk_in = walk_ff + LVL_W'(1);
            end
         end
         S_SETUP: begin
            acc_in = '0;
            tap_in = '0;
            if (point_ff) begin
               s0_in = '0;
               t0_in = '0;
               fs_in = '0;
               ft_in = '0;
            end else begin
               s0_in = xs[XW-1:16];
               t0_in = xt[XW-1:16];
               fs_in = xs[15:0];
               ft_in = xt[15:0];
            end
            state_in = S_TAP_RD;
         end
         S_TAP_RD: begin
            black_in = f_black;
            state_in = S_TAP_MUL;
         end
         S_TAP_MUL: begin
            state_in = S_TAP_ACC;
         end
         S_TAP_ACC: begin
            acc_in = acc_ff + mul_p;
            tap_in = tap_ff + 2'd1;
            state_in = (tap_ff == 2'd3) ? S_BIL_END : S_TAP_RD;
         end
         S_BIL_END: begin
            if (phase_ff) begin
               bilb_in = rnd[47:32];
               state_in = S_BLEND1;
            end else if (d_ff == 8'd0) begin
               res_in = rnd[47:32];
               state_in = S_OUT;
            end else begin
               bila_in = rnd[47:32];
               phase_in = 1'b1;
               base_in = base_ff + lvl_size(f_lw, f_lh);
               lvl_in = lvl_ff + LVL_W'(1);
               state_in = S_SETUP;
            end
         end
         S_BLEND1: begin
            state_in = S_BLEND2;
         end
         S_BLEND2: begin
            acc_in = mul_p;
            state_in = S_BLEND3;
         end
         S_BLEND3: begin
            res_in = blend[23:8];
            state_in = S_OUT;
         end
         S_BLD_RD: begin
            black_in = f_black;
            state_in = S_BLD_ACC;
         end
         S_BLD_ACC: begin
            sum_in = sum_ff + 18'(texel);
            tap_in = tap_ff + 2'd1;
            state_in = (tap_ff == 2'd3) ? S_BLD_WR : S_BLD_RD;
         end
         S_BLD_WR: begin
            sum_in = '0;
            state_in = S_BLD_RD;
            if (bs_ff == bw_mask) begin
               bs_in = '0;
               if (bt_ff == bh_mask) begin
                  bt_in = '0;
                  if (lvl_ff + LVL_W'(1) == LVL_W'(top_lvl)) begin
                     state_in = S_OUT;
                  end else begin
                     base_in = base_ff + lvl_size(f_lw, f_lh);
                     lvl_in = lvl_ff + LVL_W'(1);
                  end
               end else begin
                  bt_in = bt_ff + M'(1);
               end
            end else begin
               bs_in = bs_ff + M'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{sample_value: res_ff, is_sample: smp_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cs_ff <= cs_in;       ct_ff <= ct_in;
      norm_ff <= norm_in;   cnt_ff <= cnt_in;
      lvl_ff <= lvl_in;     walk_ff <= walk_in;   base_ff <= base_in;
      d_ff <= d_in;         point_ff <= point_in; phase_ff <= phase_in;
      s0_ff <= s0_in;       t0_ff <= t0_in;       fs_ff <= fs_in;   ft_ff <= ft_in;
      tap_ff <= tap_in;     acc_ff <= acc_in;
      bila_ff <= bila_in;   bilb_ff <= bilb_in;   res_ff <= res_in; smp_ff <= smp_in;
      black_ff <= black_in; bs_ff <= bs_in;       bt_ff <= bt_in;   sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

endmodule

[design/mipmap_trilinear_sampler.sv]
// Write: the texel is stored if in range and answered; S_OUT waits on a held response.
// Build: each coarser texel is the rounded mean of four finer texels, then a response.
// Lookup: a normalise loop, a walk to the level base, then four taps per bilinear
// level (four reads on the single memory read port) and, for a trilinear result,
// a blend in S_BLEND1 to S_BLEND3. One request at a time.
// Reset idles the sequencer and loads wrap 0, log sizes 8; texel memory is left undefined.
`timescale 1ns / 1ps
`include "mipmap_trilinear_sampler_defines.svh"
// ---------------------------------------------------------------------------
// mipmap_trilinear_sampler
// Top level: configuration registers and the sampling sequencer.
// ---------------------------------------------------------------------------

module mipmap_trilinear_sampler
   import mts_pkg::*;
#(
   parameter int MAX_LOG_SIZE = MAX_LOG_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{wrap_mode: WRAP_RESET, log_width: LOG_W_RESET,
                     log_height: LOG_H_RESET};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WRAP:  cfg_ff.wrap_mode  <= csr_data[1:0];
            REG_LOG_W: cfg_ff.log_width  <= csr_data;
            REG_LOG_H: cfg_ff.log_height <= csr_data;
            default: begin
            end
         endcase
      end
   end

   mts_seq #(.MAX_LOG_SIZE(MAX_LOG_SIZE)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // busy after every request
   `MTS_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // only lookups carry a value
   `MTS_ASSERT_IMP(a_ack_zero, clock, reset, rsp_valid && !rsp_payload.is_sample, rsp_payload.sample_value == 16'd0)

endmodule
